[rtl/swtt_pkg.sv]
// shared constants, codes and state type for the sleep wake-up timer table
// no dependencies; imported by sleep_wakeup_timer_table
`default_nettype none

package swtt_pkg;

  localparam int SLOTS     = 64;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int SCAN_W    = $clog2(SLOTS + 1);
  localparam int SLOT_IN_W = 6;
  localparam int KIND_W    = 2;
  localparam int DUR_W     = 32;
  localparam int TICK_W    = 64;

  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SLEEP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

[rtl/sleep_wakeup_timer_table.sv]
// Sleep wake-up timer table.
// Input channel (in_valid / in_stall) carries kind, slot and duration; a
// transaction is taken when in_valid is high and in_stall is low. Sleep arms
// a slot at tick count plus duration (saturating), remove disarms a slot,
// tick advances the 64-bit count.
// Output channel (out_valid / out_stall) carries woke, woken_slot,
// tick_count and last; every input transaction gives one or more output
// transactions, the final one marked by last.
// Sleep, remove and ticks that do not reach the earliest wake time give
// their single result in the cycle after acceptance.
// A tick that reaches the earliest wake time scans the wake time memory,
// one slot per cycle through its single read port, unless a due slot waits
// on a stalled receiver. Due slots come out in ascending order.
// in_stall is high while a scan runs or the output register is full and
// stalled; a stalled output transaction holds its payload.
// Synchronous reset clears the tick count and the armed bits and sets the earliest wake
// time to all ones; wake times need no clearing since only armed slots' wake times are used.
// Depends on swtt_pkg.
`default_nettype none

module sleep_wakeup_timer_table
  import swtt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [KIND_W-1:0]     kind,
  input  logic [SLOT_IN_W-1:0]  slot,
  input  logic [DUR_W-1:0]      duration,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  woke,
  output logic [SLOT_IN_W-1:0]  woken_slot,
  output logic [TICK_W-1:0]     tick_count,
  output logic                  last
);

  state_t state, state_next;

  logic [TICK_W-1:0] tick_counter;
  logic [TICK_W-1:0] earliest_wake;
  logic [SLOTS-1:0]  armed;
  logic [TICK_W-1:0] wake_mem [SLOTS];
  logic [TICK_W-1:0] rd_data;

  logic [SCAN_W-1:0] scan_idx;
  logic              chk_vld;
  logic [SLOT_W-1:0] chk_idx;
  logic              held_vld;
  logic [SLOT_W-1:0] held_slot;

  logic              out_free;
  logic              accept;
  logic              is_tick;
  logic [TICK_W-1:0] tick_inc;
  logic              tick_hit;
  logic              slot_ok;
  logic [SLOT_W-1:0] slot_idx;
  logic [TICK_W:0]   wake_sum;
  logic [TICK_W-1:0] wake_sat;
  logic              mem_we;
  logic              scan_more;
  logic              chk_due;
  logic              advance;
  logic              emit_held;
  logic              finish_go;

  logic                 out_load;
  logic                 load_woke;
  logic [SLOT_IN_W-1:0] load_slot;
  logic [TICK_W-1:0]    load_tick;
  logic                 load_last;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_tick && tick_hit) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (advance && !scan_more) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (finish_go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control and output transaction selection
  always_comb begin
    out_free  = !out_valid || !out_stall;
    in_stall  = !((state == ST_IDLE) && out_free);
    accept    = in_valid && !in_stall;
    is_tick   = (kind == KIND_TICK);
    tick_inc  = tick_counter + 64'd1;
    tick_hit  = (tick_inc >= earliest_wake);
    slot_ok   = ({1'b0, slot} < (SLOT_IN_W + 1)'(SLOTS));
    slot_idx  = slot[SLOT_W-1:0];
    wake_sum  = {1'b0, tick_counter} + {{(TICK_W + 1 - DUR_W){1'b0}}, duration};
    wake_sat  = wake_sum[TICK_W] ? {TICK_W{1'b1}} : wake_sum[TICK_W-1:0];
    mem_we    = accept && (kind == KIND_SLEEP) && slot_ok;
    scan_more = (scan_idx < SCAN_W'(SLOTS));
    chk_due   = chk_vld && armed[chk_idx] && (rd_data <= tick_counter);
    advance   = (state == ST_SCAN) && !(chk_due && held_vld && !out_free);
    emit_held = advance && chk_due && held_vld;
    finish_go = (state == ST_FINISH) && out_free;

    out_load  = 1'b0;
    load_woke = 1'b0;
    load_slot = '0;
    load_tick = tick_counter;
    load_last = 1'b1;
    unique case (state)
      ST_IDLE: begin
        out_load  = accept && !(is_tick && tick_hit);
        load_tick = is_tick ? tick_inc : tick_counter;
      end
      ST_SCAN: begin
        out_load  = emit_held;
        load_woke = 1'b1;
        load_slot = SLOT_IN_W'(held_slot);
        load_last = 1'b0;
      end
      ST_FINISH: begin
        out_load  = finish_go;
        load_woke = held_vld;
        load_slot = held_vld ? SLOT_IN_W'(held_slot) : '0;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // wake time memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) wake_mem[slot_idx] <= wake_sat;
  end

  always_ff @(posedge clk) begin
    if (advance && scan_more) rd_data <= wake_mem[scan_idx[SLOT_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      woke       <= load_woke;
      woken_slot <= load_slot;
      tick_count <= load_tick;
      last       <= load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      tick_counter  <= '0;
      earliest_wake <= {TICK_W{1'b1}};
      armed         <= '0;
      out_valid     <= 1'b0;
      scan_idx      <= '0;
      chk_vld       <= 1'b0;
      chk_idx       <= '0;
      held_vld      <= 1'b0;
      held_slot     <= '0;
    end else begin
      state <= state_next;

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        case (kind)
          KIND_TICK: begin
            tick_counter <= tick_inc;
            if (tick_hit) begin
              earliest_wake <= {TICK_W{1'b1}};
              scan_idx      <= '0;
              chk_vld       <= 1'b0;
              held_vld      <= 1'b0;
            end
          end
          KIND_SLEEP: begin
            if (slot_ok) begin
              armed[slot_idx] <= 1'b1;
              if (wake_sat < earliest_wake) earliest_wake <= wake_sat;
            end
          end
          KIND_REMOVE: begin
            if (slot_ok) armed[slot_idx] <= 1'b0;
          end
          default: begin
          end
        endcase
      end

      if (advance) begin
        if (chk_vld && armed[chk_idx]) begin
          if (chk_due) begin
            armed[chk_idx] <= 1'b0;
            held_vld       <= 1'b1;
            held_slot      <= chk_idx;
          end else if (rd_data < earliest_wake) begin
            earliest_wake <= rd_data;
          end
        end
        if (scan_more) begin
          chk_vld  <= 1'b1;
          chk_idx  <= scan_idx[SLOT_W-1:0];
          scan_idx <= scan_idx + SCAN_W'(1);
        end else begin
          chk_vld <= 1'b0;
        end
      end

      if (finish_go) held_vld <= 1'b0;
    end
  end

  // a slot waiting to be reported has already been disarmed
  a_held_disarmed: assert property (@(posedge clk) disable iff (rst)
    held_vld |-> !armed[held_slot])
    else $error("held slot still armed");

  // once the scan is over nothing left armed is due
  a_earliest_ahead: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> ((earliest_wake > tick_counter) || (&earliest_wake)))
    else $error("earliest wake time not ahead of tick count after scan");

  // the scan pointer never goes beyond one past the last slot of the table
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    scan_idx <= SCAN_W'(SLOTS))
    else $error("scan index out of range");

  // a pending check only exists inside a scan
  a_chk_in_scan: assert property (@(posedge clk) disable iff (rst)
    chk_vld |-> (state == ST_SCAN))
    else $error("slot check pending outside scan");

  // a scan that finishes loads a final transaction with last set
  a_finish_last: assert property (@(posedge clk) disable iff (rst)
    finish_go |=> (out_valid && last))
    else $error("scan finished without a last transaction");

endmodule

`default_nettype wire

[test/tb.sv]
// testbench for sleep_wakeup_timer_table: directed table then random traffic of every kind
// checks every output transaction against an in-bench timer table predictor, with fixed reports for typed directed rows
// depends on swtt_pkg and the sleep_wakeup_timer_table rtl
module tb
  import swtt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 140;
  localparam int DIR_ROWS = 20;

  typedef struct packed {
    logic                 woke;
    logic [SLOT_IN_W-1:0] wslot;
    logic [TICK_W-1:0]    ticks;
    logic                 last;
  } wake_report_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [SLOT_IN_W-1:0] slot;
    logic [DUR_W-1:0]     dur;
    logic                 typed;
    wake_report_t         report;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [KIND_W-1:0]    kind = KIND_TICK;
  logic [SLOT_IN_W-1:0] slot = '0;
  logic [DUR_W-1:0]     duration = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 woke;
  logic [SLOT_IN_W-1:0] woken_slot;
  logic [TICK_W-1:0]    tick_count;
  logic                 last;

  // predictor state
  logic [TICK_W-1:0] ticks_now;
  logic [TICK_W-1:0] earliest_due;
  logic [TICK_W-1:0] due_at [SLOTS];
  logic              armed [SLOTS];

  wake_report_t expected_reports [$];
  dir_row_t     dir_rows [DIR_ROWS];

  int errors = 0;
  int cycles = 0;
  int send_idle = 8;
  int recv_idle = 55;

  sleep_wakeup_timer_table uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .slot       (slot),
    .duration   (duration),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .woke       (woke),
    .woken_slot (woken_slot),
    .tick_count (tick_count),
    .last       (last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // output transaction check
  always @(posedge clk) begin
    wake_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        errors <= errors + 1;
        $display("%0t: expected no transaction, got woke=%0b slot=%0d tick=%0d last=%0b",
                 $time, woke, woken_slot, tick_count, last);
      end else begin
        want = expected_reports.pop_front();
        if (woke !== want.woke || woken_slot !== want.wslot ||
            tick_count !== want.ticks || last !== want.last) begin
          errors <= errors + 1;
          $display("%0t: expected woke=%0b slot=%0d tick=%0d last=%0b,",
                   $time, want.woke, want.wslot, want.ticks, want.last);
          $display("%0t:      got woke=%0b slot=%0d tick=%0d last=%0b",
                   $time, woke, woken_slot, tick_count, last);
        end
      end
    end
  end

  task automatic advance_timer_table(input logic [KIND_W-1:0] k,
                                     input logic [SLOT_IN_W-1:0] s,
                                     input logic [DUR_W-1:0] d);
    logic [TICK_W:0] sum;
    wake_report_t    rep;
    int              first;
    first = expected_reports.size();
    case (k)
      KIND_TICK: begin
        ticks_now = ticks_now + 1'b1;
        if (ticks_now >= earliest_due) begin
          earliest_due = '1;
          for (int i = 0; i < SLOTS; i++) begin
            if (armed[i]) begin
              if (due_at[i] <= ticks_now) begin
                armed[i] = 1'b0;
                expected_reports.push_back({1'b1, SLOT_IN_W'(i), ticks_now, 1'b0});
              end else if (due_at[i] < earliest_due) begin
                earliest_due = due_at[i];
              end
            end
          end
        end
      end
      KIND_SLEEP: begin
        sum = {1'b0, ticks_now} + d;
        due_at[s] = sum[TICK_W] ? '1 : sum[TICK_W-1:0];
        armed[s] = 1'b1;
        if (due_at[s] < earliest_due)
          earliest_due = due_at[s];
      end
      KIND_REMOVE: armed[s] = 1'b0;
      default: ;
    endcase
    if (expected_reports.size() == first) begin
      expected_reports.push_back({1'b0, {SLOT_IN_W{1'b0}}, ticks_now, 1'b1});
    end else begin
      rep = expected_reports.pop_back();
      rep.last = 1'b1;
      expected_reports.push_back(rep);
    end
  endtask

  // called and returns at a falling edge
  task automatic push_item(input logic [KIND_W-1:0] k,
                           input logic [SLOT_IN_W-1:0] s,
                           input logic [DUR_W-1:0] d);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    slot <= s;
    duration <= d;
    do @(posedge clk); while (in_stall);
    advance_timer_table(k, s, d);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
  endtask

  task automatic run_random_phase(input bit full_burst);
    int sent;
    int pick;
    int cnt;
    sent = 0;
    // every slot due on one tick
    if (full_burst) begin
      for (int i = 0; i < SLOTS; i++)
        push_item(KIND_SLEEP, SLOT_IN_W'(i), DUR_W'($urandom_range(1)));
      push_item(KIND_TICK, SLOT_IN_W'($urandom), $urandom);
      sent = SLOTS + 1;
    end
    while (sent < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        cnt = $urandom_range(1, 8);
        repeat (cnt) push_item(KIND_SLEEP, SLOT_IN_W'($urandom), DUR_W'($urandom_range(6)));
        sent += cnt;
        if ($urandom_range(3) == 0) begin
          push_item(KIND_REMOVE, SLOT_IN_W'($urandom), $urandom);
          sent++;
        end
        cnt = $urandom_range(1, 8);
        repeat (cnt) push_item(KIND_TICK, SLOT_IN_W'($urandom), $urandom);
        sent += cnt;
      end else begin
        push_item(KIND_W'($urandom_range(3)), SLOT_IN_W'($urandom), $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    wake_report_t rep;
    ticks_now = '0;
    earliest_due = '1;
    for (int i = 0; i < SLOTS; i++) begin
      due_at[i] = '0;
      armed[i] = 1'b0;
    end
    dir_rows = '{
      '{KIND_TICK,   6'd0,  32'd0,          1'b1, '{1'b0, 6'd0, 64'd1, 1'b1}},
      '{KIND_REMOVE, 6'd0,  32'd0,          1'b1, '{1'b0, 6'd0, 64'd1, 1'b1}},
      '{KIND_UNUSED, 6'd63, 32'hFFFF_FFFF,  1'b1, '{1'b0, 6'd0, 64'd1, 1'b1}},
      '{KIND_SLEEP,  6'd0,  32'd0,          1'b1, '{1'b0, 6'd0, 64'd1, 1'b1}},
      '{KIND_TICK,   6'd0,  32'd0,          1'b1, '{1'b1, 6'd0, 64'd2, 1'b1}},
      '{KIND_SLEEP,  6'd63, 32'hFFFF_FFFF,  1'b1, '{1'b0, 6'd0, 64'd2, 1'b1}},
      '{KIND_SLEEP,  6'd5,  32'd1,          1'b0, '0},
      '{KIND_SLEEP,  6'd2,  32'd1,          1'b0, '0},
      '{KIND_SLEEP,  6'd7,  32'd3,          1'b0, '0},
      '{KIND_REMOVE, 6'd7,  32'd0,          1'b0, '0},
      '{KIND_TICK,   6'd0,  32'd0,          1'b0, '0},
      '{KIND_SLEEP,  6'd7,  32'd2,          1'b0, '0},
      '{KIND_REMOVE, 6'd7,  32'd0,          1'b0, '0},
      '{KIND_TICK,   6'd0,  32'd0,          1'b0, '0},
      '{KIND_TICK,   6'd0,  32'd0,          1'b0, '0},
      '{KIND_SLEEP,  6'd10, 32'd0,          1'b0, '0},
      '{KIND_SLEEP,  6'd10, 32'd100,        1'b0, '0},
      '{KIND_TICK,   6'd0,  32'd0,          1'b0, '0},
      '{KIND_TICK,   6'd63, 32'hFFFF_FFFF,  1'b0, '0},
      '{KIND_REMOVE, 6'd63, 32'hFFFF_FFFF,  1'b0, '0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      push_item(dir_rows[r].kind, dir_rows[r].slot, dir_rows[r].dur);
      if (dir_rows[r].typed) begin
        rep = expected_reports.pop_back();
        expected_reports.push_back(dir_rows[r].report);
      end
    end
    // sender holds off until all results are back
    wait_for_drain();

    run_random_phase(1'b1);
    wait_for_drain();
    send_idle = 55;
    recv_idle = 8;
    run_random_phase(1'b1);
    wait_for_drain();
    send_idle = 0;
    recv_idle = 0;
    run_random_phase(1'b0);

    wait_for_drain();
    repeat (SLOTS + 8) @(posedge clk);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
